// ===== hw/rtl/qwo_pkg.sv =====
// Package for the quantized wave oscillator: payload structs, register and
// shape codes, reset values and the control struct of the shared multiplier.
// No dependencies.
package qwo_pkg;

  localparam int PhaseBitsDefault = 32;
  localparam int StepW            = 31;
  localparam int VolW             = 15;
  localparam int GainW            = 16;
  localparam int SampleW          = 16;
  localparam int ProdShift        = 17;
  localparam int CfgIdxW          = 2;
  localparam int CfgDataW         = 16;

  // multiplier operand widths: first pass |L|*vol, second pass (|L|*vol)*gain
  localparam int MulAW   = 4 + VolW;
  localparam int MulBW   = GainW;
  localparam int MulProdW = MulAW + MulBW;

  localparam logic [1:0]       ShapeReset = 2'd1;
  localparam logic [GainW-1:0] GainReset  = 16'd19661;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WAVE_SHAPE  = 2'd0,
    REG_OUTPUT_GAIN = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SHAPE_TRIANGLE = 2'd0,
    SHAPE_SAW      = 2'd1,
    SHAPE_PULSE    = 2'd2
  } shape_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_VOL,
    ST_MUL_GAIN,
    ST_FINISH
  } state_e;

  typedef enum logic {
    MUL_SEL_VOL,
    MUL_SEL_GAIN
  } mul_sel_e;

  typedef struct packed {
    logic     en;
    mul_sel_e sel;
  } mul_ctrl_t;

  // level in eighths as sign and magnitude, magnitude 0..8
  typedef struct packed {
    logic       neg;
    logic [3:0] mag;
  } level_t;

  typedef struct packed {
    logic [StepW-1:0] phase_step;
    logic [VolW-1:0]  volume;
    logic             block_end;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } out_t;

endpackage

// ===== hw/rtl/qwo_level.sv =====
// Waveform level former: maps the current phase and shape code to a level in
// eighths (-8..8) as sign and magnitude. Depends on qwo_pkg.
module qwo_level #(
  parameter int PHASE_BITS = qwo_pkg::PhaseBitsDefault
) (
  input  logic [PHASE_BITS-1:0] phase_i,
  input  logic [1:0]            shape_i,
  output qwo_pkg::level_t       level_o
);

  logic       top;
  logic [3:0] nib3;   // bits below the top bit
  logic [3:0] nib4;   // top four bits
  logic       rest;   // anything below the triangle's nibble
  logic [4:0] tri5;   // triangle level plus 8, 0..16

  assign top  = phase_i[PHASE_BITS-1];
  assign nib3 = phase_i[PHASE_BITS-2:PHASE_BITS-5];
  assign nib4 = phase_i[PHASE_BITS-1:PHASE_BITS-4];
  assign rest = |phase_i[PHASE_BITS-6:0];

  // below half: floor((half - low) / 2^(n-5)) = 16 - ceil(low / 2^(n-5))
  assign tri5 = top ? {1'b0, nib3} : (5'd16 - {1'b0, nib3} - {4'd0, rest});

  always_comb begin
    level_o = '0;
    case (shape_i)
      qwo_pkg::SHAPE_TRIANGLE: begin
        level_o.neg = (tri5 < 5'd8);
        level_o.mag = level_o.neg ? 4'(5'd8 - tri5) : 4'(tri5 - 5'd8);
      end
      qwo_pkg::SHAPE_SAW: begin
        level_o.neg = ~nib4[3];
        level_o.mag = level_o.neg ? (4'd8 - nib4) : (nib4 - 4'd8);
      end
      qwo_pkg::SHAPE_PULSE: begin
        level_o.neg = ~top;
        level_o.mag = 4'd8;
      end
      default: begin
        level_o = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/qwo_mul_unit.sv =====
// Shared multiplier: two passes per sample, level magnitude by volume, then
// that product by the output gain, into one product register. Depends on qwo_pkg.
module qwo_mul_unit (
  input  logic                         clk_i,
  input  qwo_pkg::mul_ctrl_t           ctrl_i,
  input  logic [3:0]                   level_mag_i,
  input  logic [qwo_pkg::VolW-1:0]     volume_i,
  input  logic [qwo_pkg::GainW-1:0]    gain_i,
  output logic [qwo_pkg::MulProdW-1:0] prod_o
);

  logic [qwo_pkg::MulAW-1:0]    op_a;
  logic [qwo_pkg::MulBW-1:0]    op_b;
  logic [qwo_pkg::MulProdW-1:0] prod_d, prod_q;

  always_comb begin
    if (ctrl_i.sel == qwo_pkg::MUL_SEL_VOL) begin
      op_a = qwo_pkg::MulAW'(level_mag_i);
      op_b = qwo_pkg::MulBW'(volume_i);
    end else begin
      // feed back the first pass
      op_a = prod_q[qwo_pkg::MulAW-1:0];
      op_b = gain_i;
    end
    prod_d = qwo_pkg::MulProdW'(op_a) * qwo_pkg::MulProdW'(op_b);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/quantized_wave_oscillator.sv =====
// Top level of the quantized wave oscillator: sequencer, configuration
// registers, phase accumulator, saturation and output register.
// Depends on qwo_pkg, qwo_level and qwo_mul_unit.
//
// Each input word is one sample tick. The sample is formed from the phase as
// it stood before the tick, then the phase step is added (wrapping). For each
// word the level is registered as the word is accepted, one shared multiplier
// then runs two passes (level by volume, then by gain), and the finish state
// saturates the result into the output register and advances the phase.
// in_ready_o is high only while the sequencer is idle. The output register
// lets the next word start while a sample still waits to be taken; the
// finish state holds if that register is still full. Configuration writes are
// always accepted and take effect at once; shape code 3 gives silence.
module quantized_wave_oscillator #(
  parameter int PHASE_BITS = qwo_pkg::PhaseBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  qwo_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output qwo_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [qwo_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [qwo_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int SumW = (PHASE_BITS > qwo_pkg::StepW) ? PHASE_BITS : qwo_pkg::StepW;
  localparam int UpW  = qwo_pkg::MulProdW + 1;

  qwo_pkg::state_e state_q, state_d;

  logic [1:0]                  shape_q;
  logic [qwo_pkg::GainW-1:0]   gain_q;
  logic [PHASE_BITS-1:0]       phase_q, phase_d;
  logic [qwo_pkg::StepW-1:0]   step_q;
  logic [qwo_pkg::VolW-1:0]    vol_q;
  logic                        last_q;
  qwo_pkg::level_t             level_q, level;
  logic                        out_valid_q;
  qwo_pkg::out_t               out_q;

  qwo_pkg::mul_ctrl_t           mul_ctrl;
  logic [qwo_pkg::MulProdW-1:0] prod;
  logic                         in_fire, finish, out_free;
  logic [SumW-1:0]              phase_sum;
  logic [UpW-1:0]               up_sum;
  logic [UpW-qwo_pkg::ProdShift-1:0]                 up_mag;
  logic [qwo_pkg::MulProdW-qwo_pkg::ProdShift-1:0]   dn_mag;
  logic signed [qwo_pkg::SampleW-1:0]                sample;

  qwo_level #(
    .PHASE_BITS(PHASE_BITS)
  ) u_level (
    .phase_i(phase_q),
    .shape_i(shape_q),
    .level_o(level)
  );

  qwo_mul_unit u_mul (
    .clk_i      (clk_i),
    .ctrl_i     (mul_ctrl),
    .level_mag_i(level_q.mag),
    .volume_i   (vol_q),
    .gain_i     (gain_q),
    .prod_o     (prod)
  );

  assign cfg_ready_o = 1'b1;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign in_fire     = in_valid_i & in_ready_o;

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    finish     = 1'b0;
    mul_ctrl   = '{en: 1'b0, sel: qwo_pkg::MUL_SEL_VOL};
    case (state_q)
      qwo_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = qwo_pkg::ST_MUL_VOL;
        end
      end
      qwo_pkg::ST_MUL_VOL: begin
        mul_ctrl = '{en: 1'b1, sel: qwo_pkg::MUL_SEL_VOL};
        state_d  = qwo_pkg::ST_MUL_GAIN;
      end
      qwo_pkg::ST_MUL_GAIN: begin
        mul_ctrl = '{en: 1'b1, sel: qwo_pkg::MUL_SEL_GAIN};
        state_d  = qwo_pkg::ST_FINISH;
      end
      qwo_pkg::ST_FINISH: begin
        // hold until the output register can take the word
        if (out_free) begin
          finish  = 1'b1;
          state_d = qwo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qwo_pkg::ST_IDLE;
      end
    endcase
  end

  // floor shift by 17 and saturate; negative side rounds the magnitude up
  always_comb begin
    up_sum = UpW'(prod) + UpW'((1 << qwo_pkg::ProdShift) - 1);
    up_mag = up_sum[UpW-1:qwo_pkg::ProdShift];
    dn_mag = prod[qwo_pkg::MulProdW-1:qwo_pkg::ProdShift];
    if (level_q.neg) begin
      if (up_mag > (UpW-qwo_pkg::ProdShift)'(32768)) begin
        sample = 16'sh8000;
      end else begin
        sample = $signed(16'd0 - up_mag[qwo_pkg::SampleW-1:0]);
      end
    end else begin
      if (dn_mag > (qwo_pkg::MulProdW-qwo_pkg::ProdShift)'(32767)) begin
        sample = 16'sh7fff;
      end else begin
        sample = $signed(dn_mag[qwo_pkg::SampleW-1:0]);
      end
    end
  end

  assign phase_sum = SumW'(phase_q) + SumW'(step_q);
  assign phase_d   = finish ? phase_sum[PHASE_BITS-1:0] : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qwo_pkg::ST_IDLE;
      phase_q     <= '0;
      shape_q     <= qwo_pkg::ShapeReset;
      gain_q      <= qwo_pkg::GainReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          qwo_pkg::REG_WAVE_SHAPE:  shape_q <= cfg_data_i[1:0];
          qwo_pkg::REG_OUTPUT_GAIN: gain_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      step_q  <= in_data_i.phase_step;
      vol_q   <= in_data_i.volume;
      last_q  <= in_data_i.block_end;
      level_q <= level;
    end
    if (finish) begin
      out_q.sample <= sample;
      out_q.last   <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
